[hw/rtl/srfp_pkg.sv]
// ----------------------------------------------------------------------------
// srfp_pkg: shared definitions for the sparc relocation field patcher
// relocation descriptor type, type codes, status codes and the type table
// ----------------------------------------------------------------------------
package srfp_pkg;

  // descriptor flags
  localparam int unsigned FLAG_VERIFY = 0;
  localparam int unsigned FLAG_SIGN   = 1;
  localparam int unsigned FLAG_UNALGN = 2;
  localparam int unsigned FLAG_WD16   = 3;

  // relocation types with special handling
  localparam logic [5:0] CMD_HI22     = 6'd9;
  localparam logic [5:0] CMD_GLOB_DAT = 6'd20;
  localparam logic [5:0] CMD_RELATIVE = 6'd22;
  localparam logic [5:0] CMD_HIX22    = 6'd48;
  localparam logic [5:0] CMD_LOX10    = 6'd49;

  // status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_UNIMPL   = 3'd1;
  localparam logic [2:0] ST_MISALIGN = 3'd2;
  localparam logic [2:0] ST_TGT_ALGN = 3'd3;
  localparam logic [2:0] ST_RANGE    = 3'd4;

  // scattered bit layout of wdisp16
  localparam logic [63:0] WD16_HI_MASK  = 64'h30_0000;
  localparam logic [63:0] WD16_LO_MASK  = 64'h3fff;
  localparam logic [63:0] WD16_ALL_MASK = 64'h30_3fff;
  localparam logic [63:0] WD16_SRC_HI   = 64'hc000;
  localparam logic [63:0] LOX10_OR      = 64'h1c00;

  typedef struct packed {
    logic [11:0] mask;
    logic [3:0]  flags;
    logic [3:0]  bytes;
    logic [5:0]  shift;
    logic [4:0]  bits;
  } desc_t;

  function automatic desc_t mk(input logic [11:0] mask, input logic [3:0] flags,
                               input logic [3:0] bytes, input logic [5:0] shift,
                               input logic [4:0] bits);
    desc_t d;
    d.mask  = mask;
    d.flags = flags;
    d.bytes = bytes;
    d.shift = shift;
    d.bits  = bits;
    return d;
  endfunction

  localparam logic [3:0] FV  = 4'b0001;
  localparam logic [3:0] FS  = 4'b0010;
  localparam logic [3:0] FVS = 4'b0011;
  localparam logic [3:0] FU  = 4'b0100;
  localparam logic [3:0] FVU = 4'b0101;
  localparam logic [3:0] FWD = 4'b1011;
  localparam logic [3:0] F0  = 4'b0000;

  // relocation type table, abi numbering; unlisted types have no field
  function automatic desc_t reloc_desc(input logic [5:0] cmd);
    desc_t d;
    d = '0;
    case (cmd)
      6'd1:  d = mk(12'h000, FV,  4'd1, 6'd0,  5'd0);
      6'd2:  d = mk(12'h000, FV,  4'd2, 6'd0,  5'd0);
      6'd3:  d = mk(12'h000, FV,  4'd4, 6'd0,  5'd0);
      6'd4:  d = mk(12'h000, FVS, 4'd1, 6'd0,  5'd0);
      6'd5:  d = mk(12'h000, FVS, 4'd2, 6'd0,  5'd0);
      6'd6:  d = mk(12'h000, FVS, 4'd4, 6'd0,  5'd0);
      6'd7:  d = mk(12'h000, FVS, 4'd4, 6'd2,  5'd30);
      6'd8:  d = mk(12'h000, FVS, 4'd4, 6'd2,  5'd22);
      6'd9:  d = mk(12'h000, FV,  4'd4, 6'd10, 5'd22);
      6'd10: d = mk(12'h000, FV,  4'd4, 6'd0,  5'd22);
      6'd11: d = mk(12'h000, FVS, 4'd4, 6'd0,  5'd13);
      6'd12: d = mk(12'h3ff, FS,  4'd4, 6'd0,  5'd13);
      6'd13: d = mk(12'h3ff, FS,  4'd4, 6'd0,  5'd13);
      6'd14: d = mk(12'h000, FVS, 4'd4, 6'd0,  5'd13);
      6'd15: d = mk(12'h000, F0,  4'd4, 6'd10, 5'd22);
      6'd16: d = mk(12'h3ff, FS,  4'd4, 6'd0,  5'd13);
      6'd17: d = mk(12'h000, FVS, 4'd4, 6'd10, 5'd22);
      6'd18: d = mk(12'h000, FVS, 4'd4, 6'd2,  5'd30);
      6'd20: d = mk(12'h000, F0,  4'd8, 6'd0,  5'd0);
      6'd22: d = mk(12'h000, F0,  4'd8, 6'd0,  5'd0);
      6'd23: d = mk(12'h000, FU,  4'd4, 6'd0,  5'd0);
      6'd24: d = mk(12'h000, FV,  4'd4, 6'd0,  5'd0);
      6'd25: d = mk(12'h000, F0,  4'd4, 6'd10, 5'd22);
      6'd26: d = mk(12'h3ff, F0,  4'd4, 6'd0,  5'd13);
      6'd27: d = mk(12'h000, FV,  4'd4, 6'd0,  5'd0);
      6'd28: d = mk(12'h000, FV,  4'd4, 6'd10, 5'd22);
      6'd29: d = mk(12'h3ff, FV,  4'd4, 6'd0,  5'd13);
      6'd30: d = mk(12'h000, FVS, 4'd4, 6'd0,  5'd10);
      6'd31: d = mk(12'h000, FVS, 4'd4, 6'd0,  5'd11);
      6'd32: d = mk(12'h000, FV,  4'd8, 6'd0,  5'd0);
      6'd33: d = mk(12'h3ff, FS,  4'd4, 6'd0,  5'd13);
      6'd34: d = mk(12'h000, FV,  4'd4, 6'd42, 5'd22);
      6'd35: d = mk(12'h3ff, FS,  4'd4, 6'd32, 5'd13);
      6'd36: d = mk(12'h000, F0,  4'd4, 6'd10, 5'd22);
      6'd37: d = mk(12'h000, FV,  4'd4, 6'd42, 5'd22);
      6'd38: d = mk(12'h3ff, FS,  4'd4, 6'd32, 5'd13);
      6'd39: d = mk(12'h000, F0,  4'd4, 6'd10, 5'd22);
      6'd40: d = mk(12'h000, FWD, 4'd4, 6'd2,  5'd16);
      6'd41: d = mk(12'h000, FVS, 4'd4, 6'd2,  5'd19);
      6'd43: d = mk(12'h000, F0,  4'd4, 6'd0,  5'd7);
      6'd44: d = mk(12'h000, F0,  4'd4, 6'd0,  5'd5);
      6'd45: d = mk(12'h000, F0,  4'd4, 6'd0,  5'd6);
      6'd46: d = mk(12'h000, FVS, 4'd8, 6'd0,  5'd0);
      6'd47: d = mk(12'h000, FV,  4'd8, 6'd0,  5'd0);
      6'd48: d = mk(12'h000, FV,  4'd4, 6'd10, 5'd22);
      6'd49: d = mk(12'h3ff, FS,  4'd4, 6'd0,  5'd13);
      6'd50: d = mk(12'h000, FV,  4'd4, 6'd22, 5'd22);
      6'd51: d = mk(12'h3ff, F0,  4'd4, 6'd12, 5'd10);
      6'd52: d = mk(12'hfff, F0,  4'd4, 6'd0,  5'd13);
      6'd54: d = mk(12'h000, FVU, 4'd8, 6'd0,  5'd0);
      6'd55: d = mk(12'h000, FVU, 4'd2, 6'd0,  5'd0);
      default: d = '0;
    endcase
    return d;
  endfunction

endpackage

[hw/rtl/sparc_reloc_field_patcher.sv]
// ----------------------------------------------------------------------------
// sparc_reloc_field_patcher: applies one sparc elf relocation to a field
// extracts the field, adds the relocation value, range checks, reinserts
// ----------------------------------------------------------------------------
// pipeline: an accepted input is held in the input register and then in the
//   result register before its result is offered on the result channel
// throughput: one transaction per cycle while out_ready is not held low, set
//   by the single add/shift pass between the input register and the result register
// reset: rst_n synchronous active low, clears both valid flags and sets
//   elf64_mode to 1; payload registers are not reset
module sparc_reloc_field_patcher
  import srfp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_elf64_mode,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [5:0]  in_cmd,
  input  logic [2:0]  in_place_low_bits,
  input  logic [63:0] in_old_field,
  input  logic [63:0] in_reloc_value,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_new_field,
  output logic [63:0] out_value_out,
  output logic [2:0]  out_status
);

  // mode register, always writable
  logic elf64_mode_r;

  // input stage
  logic        s1_valid_r;
  logic [5:0]  s1_cmd_r;
  logic [2:0]  s1_place_r;
  logic [63:0] s1_old_r;
  logic [63:0] s1_val_r;

  // result stage
  logic        out_valid_r;
  logic [63:0] new_field_r;
  logic [63:0] value_out_r;
  logic [2:0]  status_r;

  // result register frees up when empty or when its transaction completes
  logic out_free;
  logic s1_adv;

  assign out_free  = !out_valid_r || out_ready;
  assign s1_adv    = s1_valid_r && out_free;
  assign in_ready  = !s1_valid_r || out_free;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elf64_mode_r <= 1'b1;
    end else if (cfg_valid) begin
      elf64_mode_r <= cfg_elf64_mode;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_cmd_r   <= in_cmd;
      s1_place_r <= in_place_low_bits;
      s1_old_r   <= in_old_field;
      s1_val_r   <= in_reloc_value;
    end
  end

  // ---------------------------------------------------------------------------
  // patch logic, one pass on the registered input
  // ---------------------------------------------------------------------------
  desc_t       d;
  logic        m64;
  logic        is_hix;
  logic        is_lox;
  logic        unimpl;
  logic        misalign;
  logic [63:0] fmask;
  logic [63:0] sbm;
  logic [63:0] base;
  logic [63:0] base_keep;
  logic [63:0] fld;
  logic [4:0]  bits_m1;
  logic [63:0] sum;
  logic [63:0] core;
  logic [63:0] shr;
  logic        tgt_bad;
  logic [63:0] masked;
  logic [63:0] half;
  logic [63:0] biased;
  logic        range_bad;
  logic [63:0] ins;
  logic [63:0] new_field_nxt;
  logic [63:0] value_out_nxt;
  logic [2:0]  status_nxt;

  assign m64    = elf64_mode_r;
  assign is_hix = m64 && (s1_cmd_r == CMD_HIX22);
  assign is_lox = m64 && (s1_cmd_r == CMD_LOX10);

  always_comb begin
    d = reloc_desc(s1_cmd_r);
    // 32-bit rules: hi22 unchecked, got/relative entries are words
    if (!m64) begin
      if (s1_cmd_r == CMD_HI22) begin
        d.flags = '0;
      end
      if (s1_cmd_r == CMD_GLOB_DAT || s1_cmd_r == CMD_RELATIVE) begin
        d.bytes = 4'd4;
      end
    end
  end

  assign unimpl   = (d.bytes == 4'd0);
  assign misalign = !d.flags[FLAG_UNALGN] && ((s1_place_r & (d.bytes[2:0] - 3'd1)) != 3'd0);

  always_comb begin
    case (d.bytes)
      4'd1:    fmask = 64'h0000_0000_0000_00ff;
      4'd2:    fmask = 64'h0000_0000_0000_ffff;
      4'd4:    fmask = 64'h0000_0000_ffff_ffff;
      default: fmask = '1;
    endcase
  end

  assign sbm     = (64'd1 << d.bits) - 64'd1;
  assign bits_m1 = d.bits - 5'd1;
  assign base    = s1_old_r & fmask;

  // field extraction, wdisp16 gathers its two scattered pieces
  always_comb begin
    if (d.bits != 5'd0) begin
      if (d.flags[FLAG_WD16]) begin
        fld       = ((base & WD16_HI_MASK) >> 6) | (base & WD16_LO_MASK);
        base_keep = base & ~WD16_ALL_MASK;
      end else begin
        fld       = base & sbm;
        base_keep = base & ~sbm;
      end
      if (d.flags[FLAG_SIGN] && fld[{1'b0, bits_m1}]) begin
        fld = fld | ~sbm;
      end
    end else begin
      fld       = base;
      base_keep = '0;
    end
  end

  assign sum  = (fld << d.shift) + s1_val_r;
  assign core = s1_val_r >> d.shift;

  // shift back; branch displacements must land on a word boundary
  always_comb begin
    tgt_bad = 1'b0;
    shr     = sum;
    if (d.shift != 6'd0) begin
      if (d.shift == 6'd2 && sum[1:0] != 2'b00) begin
        tgt_bad = 1'b1;
      end else if (is_hix) begin
        shr = (~sum) >> d.shift;
      end else if (d.flags[FLAG_SIGN]) begin
        shr = $unsigned($signed(sum) >>> d.shift);
      end else begin
        shr = sum >> d.shift;
      end
    end
  end

  always_comb begin
    masked = shr;
    if (d.mask != 12'd0) begin
      masked = shr & {52'd0, d.mask};
    end
    if (is_lox) begin
      masked = masked | LOX10_OR;
    end
  end

  // signed range: value plus half of the span must stay below the span
  assign half   = 64'd1 << bits_m1;
  assign biased = masked + half;

  always_comb begin
    range_bad = 1'b0;
    if (d.flags[FLAG_VERIFY] && d.bits != 5'd0) begin
      if (d.flags[FLAG_SIGN]) begin
        range_bad = (biased & ~sbm) != 64'd0;
      end else begin
        range_bad = (masked & ~sbm) != 64'd0;
      end
    end
  end

  // reinsert into the untouched bits of the old contents
  always_comb begin
    if (d.bits != 5'd0) begin
      if (d.flags[FLAG_WD16]) begin
        ins = ((masked & WD16_SRC_HI) << 6) | (masked & WD16_LO_MASK);
      end else begin
        ins = masked & sbm;
      end
      ins = ins | base_keep;
    end else begin
      ins = masked;
    end
  end

  always_comb begin
    if (unimpl) begin
      status_nxt = ST_UNIMPL;
    end else if (misalign) begin
      status_nxt = ST_MISALIGN;
    end else if (tgt_bad) begin
      status_nxt = ST_TGT_ALGN;
    end else if (range_bad) begin
      status_nxt = ST_RANGE;
    end else begin
      status_nxt = ST_OK;
    end
    // any error zeroes the data fields
    if (status_nxt == ST_OK) begin
      new_field_nxt = ins & fmask;
      value_out_nxt = core;
    end else begin
      new_field_nxt = '0;
      value_out_nxt = '0;
    end
  end

  // ---------------------------------------------------------------------------
  // result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      new_field_r <= new_field_nxt;
      value_out_r <= value_out_nxt;
      status_r    <= status_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_new_field = new_field_r;
  assign out_value_out = value_out_r;
  assign out_status    = status_r;

endmodule
